FILE: hw/rtl/xla_pkg.sv
package xla_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LAG_W    = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // write the incoming word and read the delayed samples
    logic load_out;    // move the delayed samples into the output register
    logic calc_start;  // begin the correlation sweep over the finished window
  } xla_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic window_end;  // the word just taken completed a window
    logic calc_done;   // correlation sweep finished; new lag latched while this is high
  } xla_sts_t;

endpackage

FILE: hw/rtl/xla_if.sv
interface xla_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [xla_pkg::SAMPLE_W-1:0]  sample_a;
  logic signed [xla_pkg::SAMPLE_W-1:0]  sample_b;

  modport source (output valid, output sample_a, output sample_b, input ready);
  modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

interface xla_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [xla_pkg::SAMPLE_W-1:0]  aligned_a;
  logic signed [xla_pkg::SAMPLE_W-1:0]  aligned_b;
  logic signed [xla_pkg::LAG_W-1:0]     current_lag;

  modport source (output valid, output aligned_a, output aligned_b, output current_lag,
                  input ready);
  modport sink   (input valid, input aligned_a, input aligned_b, input current_lag,
                  output ready);
endinterface

FILE: hw/rtl/xla_ram.sv
module xla_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/xla_ctrl.sv
module xla_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xla_pkg::xla_cmd_t cmd_o,
  input  xla_pkg::xla_sts_t sts_i
);
  import xla_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, load;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = (state_q == S_READ) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d          = state_q;
    cmd_o.accept     = accept;
    cmd_o.load_out   = load;
    cmd_o.calc_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_READ;
      end
      S_READ: begin
        if (load) begin
          if (sts_i.window_end) begin
            state_d          = S_CALC;
            cmd_o.calc_start = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CALC: begin
        if (sts_i.calc_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // The output register is only reloaded once its previous word has gone.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // A finished sweep is only reported while the controller waits for it.
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.calc_done |-> (state_q == S_CALC))
    else $error("sweep done outside calculation");

  // Every accepted word is followed by its output read.
  a_accept_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_READ))
    else $error("accepted word not read out");

endmodule

FILE: hw/rtl/xla_datapath.sv
module xla_datapath #(
  parameter int unsigned WINDOW = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic signed [xla_pkg::SAMPLE_W-1:0]    sample_a_i,
  input  logic signed [xla_pkg::SAMPLE_W-1:0]    sample_b_i,
  output logic signed [xla_pkg::SAMPLE_W-1:0]    aligned_a_o,
  output logic signed [xla_pkg::SAMPLE_W-1:0]    aligned_b_o,
  output logic signed [xla_pkg::LAG_W-1:0]       current_lag_o,
  input  xla_pkg::xla_cmd_t                      cmd_i,
  output xla_pkg::xla_sts_t                      sts_o
);
  import xla_pkg::*;

  localparam int unsigned BDEPTH = 2 * WINDOW - 1;
  localparam int unsigned AW     = $clog2(WINDOW);
  localparam int unsigned BW     = $clog2(BDEPTH);
  localparam int unsigned ACC_W  = 2 * SAMPLE_W + $clog2(WINDOW) + 1;
  localparam int unsigned PROD_W = 2 * SAMPLE_W;

  // Circular buffer pointers and fill tracking.
  logic [AW-1:0] wp_a_q, fill_q;
  logic [BW-1:0] wp_b_q;
  logic          wrap_a_q, wrap_b_q, win_end_q;
  logic [BW-1:0] lag_k_q;   // peak index in use; lag is this minus WINDOW-1

  // Output-path read.
  logic [AW-1:0] a_out_addr;
  logic [BW-1:0] b_out_addr;
  logic          a_ok_q, b_ok_q, byp_q;
  logic signed [SAMPLE_W-1:0] byp_b_q;

  // Correlation sweep.
  logic          run_q, first_q;
  logic [BW-1:0] k_q, k_next;
  logic [AW-1:0] n_q, na_q;
  logic [AW-1:0] a_calc_addr;
  logic [BW-1:0] b_calc_addr;
  logic [AW:0]   a_sum;
  logic [BW:0]   b_sum;
  logic          term_last, sweep_last;
  logic          v1_q, f1_q, l1_q, z1_q;
  logic [BW-1:0] k1_q;
  logic          v2_q, f2_q, l2_q, z2_q;
  logic [BW-1:0] k2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, best_q, acc_sum;
  logic [BW-1:0] best_k_q;
  logic          done_q;

  logic [AW-1:0] a_raddr;
  logic [BW-1:0] b_raddr;
  logic          re;
  logic signed [SAMPLE_W-1:0] a_rdata, b_rdata;
  logic signed [31:0] lag_full;

  // Sample WINDOW-1 words back sits one place after the write pointer.
  assign a_out_addr = (wp_a_q == AW'(WINDOW - 1)) ? '0 : wp_a_q + AW'(1);
  assign b_out_addr = (wp_b_q >= lag_k_q) ? wp_b_q - lag_k_q
                                          : BW'(({1'b0, wp_b_q} + (BW+1)'(BDEPTH))
                                                - {1'b0, lag_k_q});

  // Window position p of stream a lives at wp_a + p, position n of b at wp_b + WINDOW-1 + n.
  assign a_sum       = {1'b0, wp_a_q} + {1'b0, na_q};
  assign a_calc_addr = (a_sum >= (AW+1)'(WINDOW)) ? AW'(a_sum - (AW+1)'(WINDOW)) : AW'(a_sum);
  assign b_sum       = {1'b0, wp_b_q} + (BW+1)'(WINDOW - 1) + (BW+1)'(n_q);
  assign b_calc_addr = (b_sum >= (BW+1)'(BDEPTH)) ? BW'(b_sum - (BW+1)'(BDEPTH)) : BW'(b_sum);

  assign a_raddr = run_q ? a_calc_addr : a_out_addr;
  assign b_raddr = run_q ? b_calc_addr : b_out_addr;
  assign re      = run_q || cmd_i.accept;

  xla_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (wp_a_q),
    .wdata_i (sample_a_i),
    .re_i    (re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  xla_ram #(.WIDTH(SAMPLE_W), .DEPTH(BDEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (wp_b_q),
    .wdata_i (sample_b_i),
    .re_i    (re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_a_q    <= '0;
      wp_b_q    <= '0;
      wrap_a_q  <= 1'b0;
      wrap_b_q  <= 1'b0;
      fill_q    <= '0;
      win_end_q <= 1'b0;
    end else if (cmd_i.accept) begin
      wp_a_q    <= (wp_a_q == AW'(WINDOW - 1)) ? '0 : wp_a_q + AW'(1);
      wp_b_q    <= (wp_b_q == BW'(BDEPTH - 1)) ? '0 : wp_b_q + BW'(1);
      if (wp_a_q == AW'(WINDOW - 1)) wrap_a_q <= 1'b1;
      if (wp_b_q == BW'(BDEPTH - 1)) wrap_b_q <= 1'b1;
      win_end_q <= (fill_q == AW'(WINDOW - 1));
      fill_q    <= (fill_q == AW'(WINDOW - 1)) ? '0 : fill_q + AW'(1);
    end
  end

  // Entries never written read as zero; a zero lag index means the current word itself.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      a_ok_q  <= wrap_a_q || (a_out_addr < wp_a_q);
      b_ok_q  <= wrap_b_q || (b_out_addr < wp_b_q);
      byp_q   <= (lag_k_q == '0);
      byp_b_q <= sample_b_i;
    end
  end

  assign lag_full = $signed({1'b0, 31'(lag_k_q)}) - 32'(WINDOW - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      aligned_a_o   <= a_ok_q ? a_rdata : '0;
      aligned_b_o   <= byp_q ? byp_b_q : (b_ok_q ? b_rdata : '0);
      current_lag_o <= lag_full[LAG_W-1:0];
    end
  end

  // Sweep sequencer: one product term issued per cycle.
  assign term_last  = (n_q == AW'(WINDOW - 1)) || (na_q == AW'(WINDOW - 1));
  assign sweep_last = term_last && (k_q == BW'(BDEPTH - 1));
  assign k_next     = k_q + BW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      first_q <= 1'b0;
      k_q     <= '0;
      n_q     <= '0;
      na_q    <= '0;
    end else if (cmd_i.calc_start) begin
      run_q   <= 1'b1;
      first_q <= 1'b1;
      k_q     <= '0;
      n_q     <= AW'(WINDOW - 1);
      na_q    <= '0;
    end else if (run_q) begin
      if (term_last) begin
        first_q <= 1'b1;
        if (sweep_last) begin
          run_q <= 1'b0;
        end else begin
          k_q <= k_next;
          if (k_next <= BW'(WINDOW - 1)) begin
            n_q  <= AW'(BW'(WINDOW - 1) - k_next);
            na_q <= '0;
          end else begin
            n_q  <= '0;
            na_q <= AW'(k_next - BW'(WINDOW - 1));
          end
        end
      end else begin
        first_q <= 1'b0;
        n_q     <= n_q + AW'(1);
        na_q    <= na_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= run_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q   <= first_q;
    l1_q   <= term_last;
    z1_q   <= sweep_last;
    k1_q   <= k_q;
    f2_q   <= f1_q;
    l2_q   <= l1_q;
    z2_q   <= z1_q;
    k2_q   <= k1_q;
    prod_q <= a_rdata * b_rdata;
  end

  assign acc_sum = (f2_q ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q   <= '0;
      best_k_q <= '0;
      done_q   <= 1'b0;
      lag_k_q  <= BW'(WINDOW - 1);
    end else begin
      done_q <= v2_q && z2_q;
      if (cmd_i.calc_start) begin
        best_q   <= '0;
        best_k_q <= '0;
      end else if (v2_q && l2_q && (acc_sum > best_q)) begin
        best_q   <= acc_sum;
        best_k_q <= k2_q;
      end
      if (done_q) lag_k_q <= best_k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) acc_q <= acc_sum;
  end

  assign sts_o.window_end = win_end_q;
  assign sts_o.calc_done  = done_q;

  // The sweep never overlaps the intake of new words.
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> (!run_q && !v1_q && !v2_q))
    else $error("word accepted during correlation sweep");

  // The lag index in use always addresses inside the stream b history.
  a_lag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lag_k_q <= BW'(BDEPTH - 1))
    else $error("lag index out of range");

  // Completion is reported in the cycle after the final term is summed.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(v2_q && z2_q))
    else $error("spurious sweep completion");

endmodule

FILE: hw/rtl/xcorr_lag_aligner_core.sv
// Cross-correlation lag aligner. Each accepted word (a pair of signed samples)
// yields one output word: stream a delayed by WINDOW-1 words and stream b delayed
// by WINDOW-1 plus the current lag, with that lag. An ordinary word is read from
// the sample histories as it is accepted and moves into the output register once
// that register is free; only then is the input ready again. The output register
// is free to hold a word while the next one is taken. Every WINDOW-th word starts
// a correlation sweep over all 2*WINDOW-1 lags on a single multiply-accumulate
// unit, one product per cycle, for WINDOW*WINDOW terms; no word is accepted
// during the sweep. The new lag applies from the word after the window. The
// sample histories need no clearing pass after reset.
module xcorr_lag_aligner_core #(
  parameter int unsigned WINDOW = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  xla_in_if.sink    in_i,
  xla_out_if.source out_o
);
  import xla_pkg::*;

  xla_cmd_t cmd;
  xla_sts_t sts;

  xla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  xla_datapath #(.WINDOW(WINDOW)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_a_i    (in_i.sample_a),
    .sample_b_i    (in_i.sample_b),
    .aligned_a_o   (out_o.aligned_a),
    .aligned_b_o   (out_o.aligned_b),
    .current_lag_o (out_o.current_lag),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

FILE: sim/xla_align_checker.sv
module xla_align_checker #(
  parameter int unsigned WINDOW = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  xla_in_if    in_i,
  xla_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import xla_pkg::*;

  localparam int BDEPTH = 2 * WINDOW - 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] aligned_a;
    logic signed [SAMPLE_W-1:0] aligned_b;
    logic signed [LAG_W-1:0]    current_lag;
  } aligned_word_t;

  logic signed [SAMPLE_W-1:0] a_hist [WINDOW];
  logic signed [SAMPLE_W-1:0] b_hist [BDEPTH];
  int            lag_in_use;
  int            fill;
  aligned_word_t aligned_q [$];

  assign pending_o = aligned_q.size();

  // Full cross-correlation over the finished window; the first strictly
  // greatest positive sum sets the lag, otherwise the most negative lag.
  function automatic int peak_lag();
    longint best;
    longint acc;
    int     best_k;
    int     m;
    int     na;
    best   = 0;
    best_k = 0;
    for (int k = 0; k < BDEPTH; k++) begin
      m   = k - (WINDOW - 1);
      acc = 0;
      for (int n = 0; n < WINDOW; n++) begin
        na = n + m;
        if (na >= 0 && na < WINDOW) begin
          acc += longint'(a_hist[WINDOW-1-na]) * longint'(b_hist[WINDOW-1-n]);
        end
      end
      if (acc > best) begin
        best   = acc;
        best_k = k;
      end
    end
    return best_k - (WINDOW - 1);
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    aligned_word_t w;
    aligned_word_t got;
    int            bidx;
    if (!rst_ni) begin
      foreach (a_hist[i]) a_hist[i] = '0;
      foreach (b_hist[i]) b_hist[i] = '0;
      lag_in_use   = 0;
      fill         = 0;
      fail_count_o = 0;
      aligned_q.delete();
    end else begin
      if (in_i.valid && in_i.ready) begin
        for (int i = WINDOW - 1; i > 0; i--) a_hist[i] = a_hist[i-1];
        for (int i = BDEPTH - 1; i > 0; i--) b_hist[i] = b_hist[i-1];
        a_hist[0] = in_i.sample_a;
        b_hist[0] = in_i.sample_b;
        bidx = WINDOW - 1 + lag_in_use;
        if (bidx < 0) bidx = 0;
        if (bidx > BDEPTH - 1) bidx = BDEPTH - 1;
        w.aligned_a   = a_hist[WINDOW-1];
        w.aligned_b   = b_hist[bidx];
        w.current_lag = lag_in_use[LAG_W-1:0];
        aligned_q.push_back(w);
        fill++;
        if (fill >= WINDOW) begin
          fill       = 0;
          lag_in_use = peak_lag();
        end
      end
      if (out_i.valid && out_i.ready) begin
        if (aligned_q.size() == 0) begin
          $error("output word with no expected word waiting");
          fail_count_o++;
        end else begin
          w   = aligned_q.pop_front();
          got = {out_i.aligned_a, out_i.aligned_b, out_i.current_lag};
          check_field("aligned_a", w.aligned_a, got.aligned_a);
          check_field("aligned_b", w.aligned_b, got.aligned_b);
          check_field("current_lag", w.current_lag, got.current_lag);
        end
      end
    end
  end
endmodule

FILE: sim/xcorr_lag_aligner_core_tb.sv
module xcorr_lag_aligner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xla_pkg::*;

  localparam int WINDOW    = 64;
  localparam int N_RANDOM  = 1880;
  localparam int CALM_TAIL = 200;
  localparam int STALL_MAX = 20000;
  localparam int SIG_LEN   = N_RANDOM + 3 * WINDOW;

  typedef enum int {
    SIG_DELAYED,
    SIG_INVERTED,
    SIG_UNRELATED,
    SIG_SILENT,
    SIG_RAILS
  } sig_mode_e;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   calm;
  bit   hold_req;
  bit   hold_done;
  int   idle_cycles;

  xla_in_if  in_ch ();
  xla_out_if out_ch ();

  xcorr_lag_aligner_core #(.WINDOW(WINDOW)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  xla_align_checker #(.WINDOW(WINDOW)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // A long receiver hold-off lets the block fill up and stall its input.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one word and returns once it has been taken; may idle first.
  task automatic send_word(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sample_a <= a;
    in_ch.sample_b <= b;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] sig [SIG_LEN];
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    sig_mode_e mode;
    int        delay;
    int        idx;
    calm           = 1'b0;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.sample_a <= '0;
    in_ch.sample_b <= '0;
    @(posedge clk_i iff rst_ni);

    // Extremes and sign patterns, then a silent stretch of zero words.
    send_word(16'sh7fff, 16'sh7fff);
    send_word(-16'sh8000, -16'sh8000);
    send_word(16'sh7fff, -16'sh8000);
    send_word(-16'sh8000, 16'sh7fff);
    send_word(16'sh5555, 16'shaaaa);
    send_word(-16'sh1, 16'sh1);
    send_word(16'sh0, -16'sh1);
    for (int i = 0; i < 18; i++) send_word('0, '0);

    for (int i = 0; i < SIG_LEN; i++) sig[i] = SAMPLE_W'($urandom);
    mode  = SIG_DELAYED;
    delay = 0;
    for (int t = 0; t < N_RANDOM; t++) begin
      if (t % WINDOW == 0) begin
        case ($urandom_range(0, 9))
          0:       mode = SIG_INVERTED;
          1:       mode = SIG_UNRELATED;
          2:       mode = SIG_SILENT;
          3:       mode = SIG_RAILS;
          default: mode = SIG_DELAYED;
        endcase
        delay = $urandom_range(0, 2 * (WINDOW - 1)) - (WINDOW - 1);
        if ($urandom_range(0, 3) == 0) delay = $urandom_range(0, 4) - 2;
      end
      if (t == 600) hold_req = 1'b1;
      if (t == N_RANDOM - CALM_TAIL) calm = 1'b1;
      idx = t + WINDOW + delay;
      a   = sig[t + WINDOW];
      case (mode)
        SIG_DELAYED:   b = sig[idx];
        SIG_INVERTED:  b = -sig[idx];
        SIG_UNRELATED: b = SAMPLE_W'($urandom);
        SIG_SILENT: begin
          a = '0;
          b = '0;
        end
        default: begin
          a = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
          b = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
        end
      endcase
      send_word(a, b);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
